// ===== design/lbfap_pkg.sv =====
// Shared types and constants for the lifetime-aware best-fit arena planner.
// No dependencies; used by the planner and by its port checker.
package lbfap_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int ALIGN_BYTES_DEF = 256;

    localparam int ADDR_W  = 48;   // arena offsets and sizes
    localparam int SIZE_W  = 43;   // batch times per-request size
    localparam int BATCH_W = 11;
    localparam int REQ_W   = 32;
    localparam int STEP_W  = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ALIGN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [ADDR_W-1:0] bytes;
        logic [STEP_W-1:0] last_step;
    } t_block;

endpackage

// ===== design/lifetime_best_fit_arena_planner.sv =====
// An item runs through the scan, align and finish states from accept to its result beat;
// the scan reads one block table entry per cycle while the arena end remainder by
// ALIGN_BYTES is formed in four reciprocal steps beside it.
// One item at a time: a new item is taken only once the last result beat is written; a
// result beat that waits on the output holds the next item in its last state.
// Reset (synchronous, active low) clears the control state, block count, arena end, batch to 1.
module lifetime_best_fit_arena_planner
    import lbfap_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int ALIGN_BYTES = ALIGN_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [BATCH_W-1:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_new_plan,
    input  logic [REQ_W-1:0]   i_per_request_bytes,
    input  logic [STEP_W-1:0]  i_first_step,
    input  logic [STEP_W-1:0]  i_last_step,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_offset,
    output logic               o_reused,
    output logic [ADDR_W-1:0]  o_arena_size,
    output logic               o_error
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

    // Remainder unit: the arena end is taken twelve bits at a time from the top.
    localparam int DIG_W = 12;
    localparam int NDIG  = ADDR_W / DIG_W;
    localparam int DG_W  = $clog2(NDIG);
    localparam int V_W   = 2 * DIG_W;
    localparam int M_W   = V_W + 1;
    localparam int P_W   = V_W + M_W;
    localparam int PAD_W = DIG_W + 1;
    localparam int SH    = V_W + $clog2(ALIGN_BYTES);
    localparam longint unsigned RECIP_L =
        ((64'd1 << SH) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [M_W-1:0]   RECIP   = M_W'(RECIP_L);
    localparam logic [V_W-1:0]   ALIGN_V = V_W'(ALIGN_BYTES);
    localparam logic [PAD_W-1:0] ALIGN_P = PAD_W'(ALIGN_BYTES);

    t_state r_state, n_state;
    logic [BATCH_W-1:0] r_batch;
    logic [CW-1:0]      r_count, n_count;
    logic [ADDR_W-1:0]  r_arena, n_arena;
    logic [REQ_W-1:0]   r_req, n_req;
    logic [STEP_W-1:0]  r_first, n_first;
    logic [STEP_W-1:0]  r_last, n_last;
    logic [SIZE_W-1:0]  r_size;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_pend_idx, n_pend_idx;
    logic               r_found, n_found;
    logic [IW-1:0]      r_best_idx, n_best_idx;
    logic [ADDR_W-1:0]  r_best_bytes, n_best_bytes;
    logic [ADDR_W-1:0]  r_best_off, n_best_off;
    logic               r_mod_busy, n_mod_busy;
    logic               r_mod_ph, n_mod_ph;
    logic [DG_W-1:0]    r_dig, n_dig;
    logic [DIG_W-1:0]   r_rem, n_rem;
    logic [P_W-1:0]     r_prod;
    logic [ADDR_W:0]    r_base, n_base;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_offset, n_offset;
    logic               r_reused, n_reused;
    logic [ADDR_W-1:0]  r_arena_size, n_arena_size;
    logic               r_error, n_error;

    logic               in_acc;
    logic               out_free;
    logic [V_W-1:0]     mod_v;
    logic [V_W-1:0]     quo;
    logic [V_W-1:0]     quo_a;
    logic [V_W-1:0]     mod_diff;
    logic [PAD_W-1:0]   pad;
    logic [ADDR_W+1:0]  end_w;
    logic [ADDR_W-1:0]  size48;
    logic               fits;
    logic               append_bad;

    // Block table: one synchronous memory, one write and one read port.
    t_block mem [MAX_BLOCKS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    t_block        mem_wdata;
    t_block        r_rd_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_rd_idx[IW-1:0]];
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign o_out_valid  = r_out_valid;
    assign o_offset     = r_offset;
    assign o_reused     = r_reused;
    assign o_arena_size = r_arena_size;
    assign o_error      = r_error;

    assign size48 = ADDR_W'(r_size);
    // Each step folds the next digit into the running remainder: the quotient comes from
    // a fixed reciprocal product, and the remainder is what is left after quotient times
    // the alignment is taken away.
    assign mod_v    = {r_rem, r_arena[DIG_W*r_dig +: DIG_W]};
    assign quo      = V_W'(r_prod >> SH);
    assign quo_a    = quo * ALIGN_V;
    assign mod_diff = mod_v - quo_a;
    assign pad      = (r_rem == '0) ? '0 : (ALIGN_P - {1'b0, r_rem});
    assign end_w  = {1'b0, r_base} + {{(ADDR_W + 2 - SIZE_W){1'b0}}, r_size};
    assign append_bad = (r_count >= MAX_C) || r_base[ADDR_W] || (end_w[ADDR_W+1:ADDR_W] != 2'b00);
    // A candidate must be free before this first use, large enough and below the best so far.
    assign fits = (r_rd_data.last_step < r_first) && (r_rd_data.bytes >= size48) &&
                  (!r_found || (r_rd_data.bytes < r_best_bytes));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_arena      = r_arena;
        n_req        = r_req;
        n_first      = r_first;
        n_last       = r_last;
        n_rd_idx     = r_rd_idx;
        n_pend       = 1'b0;
        n_pend_idx   = r_rd_idx[IW-1:0];
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best_bytes = r_best_bytes;
        n_best_off   = r_best_off;
        n_mod_busy   = r_mod_busy;
        n_mod_ph     = r_mod_ph;
        n_dig        = r_dig;
        n_rem        = r_rem;
        n_base       = r_base;
        n_out_valid  = r_out_valid && i_out_stall;
        n_offset     = r_offset;
        n_reused     = r_reused;
        n_arena_size = r_arena_size;
        n_error      = r_error;
        mem_we       = 1'b0;
        mem_waddr    = r_best_idx;
        mem_wdata    = '{offset: r_best_off, bytes: r_best_bytes, last_step: r_last};

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state    = ST_SCAN;
                    n_req      = i_per_request_bytes;
                    n_first    = i_first_step;
                    n_last     = (i_last_step < i_first_step) ? i_first_step : i_last_step;
                    n_rd_idx   = '0;
                    n_found    = 1'b0;
                    n_mod_busy = 1'b1;
                    n_mod_ph   = 1'b0;
                    n_dig      = DG_W'(NDIG - 1);
                    n_rem      = '0;
                    if (i_new_plan) begin
                        n_count = '0;
                        n_arena = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_idx < r_count) begin
                    n_pend   = 1'b1;
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_pend && fits) begin
                    n_found      = 1'b1;
                    n_best_idx   = r_pend_idx;
                    n_best_bytes = r_rd_data.bytes;
                    n_best_off   = r_rd_data.offset;
                end
                // Remainder of the arena end, one digit per two-phase step from the top.
                if (r_mod_busy) begin
                    if (!r_mod_ph) begin
                        n_mod_ph = 1'b1;
                    end else begin
                        n_mod_ph = 1'b0;
                        n_rem    = mod_diff[DIG_W-1:0];
                        if (r_dig == '0) begin
                            n_mod_busy = 1'b0;
                        end else begin
                            n_dig = r_dig - 1'b1;
                        end
                    end
                end
                if (!r_mod_busy && !r_pend && (r_rd_idx == r_count)) begin
                    n_state = ST_ALIGN;
                end
            end
            ST_ALIGN: begin
                n_base  = {1'b0, r_arena} + {{(ADDR_W + 1 - PAD_W){1'b0}}, pad};
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    if (r_found) begin
                        mem_we       = 1'b1;
                        n_offset     = r_best_off;
                        n_reused     = 1'b1;
                        n_arena_size = r_arena;
                        n_error      = 1'b0;
                    end else if (append_bad) begin
                        n_offset     = '0;
                        n_reused     = 1'b0;
                        n_arena_size = r_arena;
                        n_error      = 1'b1;
                    end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = r_count[IW-1:0];
                        mem_wdata    = '{offset: r_base[ADDR_W-1:0], bytes: size48,
                                         last_step: r_last};
                        n_count      = r_count + 1'b1;
                        n_arena      = end_w[ADDR_W-1:0];
                        n_offset     = r_base[ADDR_W-1:0];
                        n_reused     = 1'b0;
                        n_arena_size = end_w[ADDR_W-1:0];
                        n_error      = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_batch     <= BATCH_W'(1);
            r_count     <= '0;
            r_arena     <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_mod_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_arena     <= n_arena;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_mod_busy  <= n_mod_busy;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_batch <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_first      <= n_first;
        r_last       <= n_last;
        r_size       <= {{(SIZE_W - BATCH_W){1'b0}}, r_batch} *
                        {{(SIZE_W - REQ_W){1'b0}}, r_req};
        r_rd_idx     <= n_rd_idx;
        r_pend_idx   <= n_pend_idx;
        r_best_idx   <= n_best_idx;
        r_best_bytes <= n_best_bytes;
        r_best_off   <= n_best_off;
        r_mod_ph     <= n_mod_ph;
        r_dig        <= n_dig;
        r_rem        <= n_rem;
        r_prod       <= P_W'(mod_v) * P_W'(RECIP);
        r_base       <= n_base;
        r_offset     <= n_offset;
        r_reused     <= n_reused;
        r_arena_size <= n_arena_size;
        r_error      <= n_error;
    end

endmodule

// ===== design/lbfap_checker.sv =====
// Port-level checks for the arena planner, bound to its top level.
// Depends on lbfap_pkg for field widths.
module lbfap_checker
    import lbfap_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [ADDR_W-1:0]  o_offset,
    input logic               o_reused,
    input logic [ADDR_W-1:0]  o_arena_size,
    input logic               o_error
);

    // A held result beat keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_offset) &&
        $stable(o_arena_size) && $stable(o_reused) && $stable(o_error))
        else $error("result beat changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> (o_offset == '0) && !o_reused)
        else $error("error beat carries an offset or reuse flag");

    a_in_arena: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_error |-> o_offset <= o_arena_size)
        else $error("offset lies beyond the arena end");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("block took no time for an accepted beat");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

endmodule

bind lifetime_best_fit_arena_planner lbfap_checker u_lbfap_checker (.*);

// ===== bench/tb_lifetime_best_fit_arena_planner.sv =====
// Self-checking testbench for lifetime_best_fit_arena_planner: a predictor of the
// block table and arena end checks every result beat under random idling and stalls.
// Depends on lbfap_pkg and the planner RTL only.
`timescale 1ns / 100ps

module tb_lifetime_best_fit_arena_planner;
    import lbfap_pkg::*;

    localparam int N_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int ALIGN       = ALIGN_BYTES_DEF;
    localparam int HOLD_CYCLES = 600;
    localparam int STUCK_LIMIT = 5000;
    localparam int TAIL_CYCLES = 80;
    localparam logic [63:0] ADDR_MAX = (64'd1 << ADDR_W) - 64'd1;

    typedef struct packed {
        logic              new_plan;
        logic [REQ_W-1:0]  per_req;
        logic [STEP_W-1:0] first_step;
        logic [STEP_W-1:0] last_step;
    } t_buf_req;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic              reused;
        logic [ADDR_W-1:0] arena_size;
        logic              error;
    } t_placement;

    typedef enum {PLAN_NORMAL, PLAN_FILL, PLAN_HUGE, PLAN_NOISE} t_plan_kind;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [BATCH_W-1:0] i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [ADDR_W-1:0]  o_offset;
    logic               o_reused;
    logic [ADDR_W-1:0]  o_arena_size;
    logic               o_error;
    t_buf_req           offered = '0;

    lifetime_best_fit_arena_planner #(
        .MAX_BLOCKS (N_BLOCKS),
        .ALIGN_BYTES(ALIGN)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_new_plan         (offered.new_plan),
        .i_per_request_bytes(offered.per_req),
        .i_first_step       (offered.first_step),
        .i_last_step        (offered.last_step),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_offset           (o_offset),
        .o_reused           (o_reused),
        .o_arena_size       (o_arena_size),
        .o_error            (o_error)
    );

    // Predicted planner state.
    logic [63:0]       tbl_offset[N_BLOCKS];
    logic [63:0]       tbl_bytes[N_BLOCKS];
    logic [STEP_W-1:0] tbl_last[N_BLOCKS];
    int                tbl_count = 0;
    logic [63:0]       arena_top = '0;
    logic [63:0]       batch_reg = 64'd1;

    t_buf_req   pending_bufs[$];
    t_placement due_placements[$];

    bit offering = 1'b0;
    bit beat_taken = 1'b0;
    bit in_idle_en = 1'b1;
    bit out_idle_en = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int stuck_cycles = 0;
    int fails = 0;
    int bufs_sent = 0;
    int reuses_seen = 0;
    int errors_seen = 0;
    int settings_used = 1;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_placement place_buffer(t_buf_req b);
        logic [STEP_W-1:0] last;
        logic [63:0]       need;
        logic [63:0]       base;
        logic [63:0]       top;
        int                best;
        t_placement        p;
        if (b.new_plan) begin
            tbl_count = 0;
            arena_top = '0;
        end
        last = (b.last_step < b.first_step) ? b.first_step : b.last_step;
        need = batch_reg * 64'(b.per_req);
        best = -1;
        // Best fit: smallest free block that is large enough, lowest index on a tie.
        for (int k = 0; k < tbl_count; k++) begin
            if (tbl_last[k] < b.first_step && tbl_bytes[k] >= need &&
                (best < 0 || tbl_bytes[k] < tbl_bytes[best]))
                best = k;
        end
        if (best >= 0) begin
            tbl_last[best] = last;
            p = '{offset: tbl_offset[best][ADDR_W-1:0], reused: 1'b1,
                  arena_size: arena_top[ADDR_W-1:0], error: 1'b0};
            return p;
        end
        base = ((arena_top + 64'(ALIGN) - 64'd1) / 64'(ALIGN)) * 64'(ALIGN);
        top  = base + need;
        if (tbl_count >= N_BLOCKS || base > ADDR_MAX || top > ADDR_MAX) begin
            p = '{offset: '0, reused: 1'b0, arena_size: arena_top[ADDR_W-1:0], error: 1'b1};
            return p;
        end
        tbl_offset[tbl_count] = base;
        tbl_bytes[tbl_count]  = need;
        tbl_last[tbl_count]   = last;
        tbl_count++;
        arena_top = top;
        p = '{offset: base[ADDR_W-1:0], reused: 1'b0, arena_size: top[ADDR_W-1:0], error: 1'b0};
        return p;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 30);
        return $urandom_range(60, 250);
    endfunction

    function automatic void push_buf(bit np, logic [31:0] bytes, int first, int last);
        t_buf_req b;
        b.new_plan   = np;
        b.per_req    = bytes;
        b.first_step = STEP_W'(first);
        b.last_step  = STEP_W'(last);
        pending_bufs.insert(pending_bufs.size(), b);
    endfunction

    function automatic int clamp_step(int s);
        return (s < 0) ? 0 : (s > 255) ? 255 : s;
    endfunction

    // One plan: a new_plan beat, then buffers, sorted by first use unless noise.
    function automatic int gen_plan(t_plan_kind kind);
        int          n;
        int          step;
        int          last;
        logic [31:0] bytes;
        case (kind)
            PLAN_FILL: n = $urandom_range(66, 72);
            PLAN_HUGE: n = $urandom_range(30, 40);
            PLAN_NOISE: n = $urandom_range(5, 15);
            default: n = $urandom_range(4, 40);
        endcase
        step = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) begin
            case (kind)
                PLAN_NOISE: begin
                    push_buf(k == 0 || $urandom_range(0, 7) == 0, $urandom,
                             $urandom_range(0, 255), $urandom_range(0, 255));
                end
                PLAN_FILL: begin
                    // Lifetimes run to the last step, so no block is ever free again.
                    push_buf(k == 0, $urandom_range(0, 300), step, 255);
                    step = clamp_step(step + $urandom_range(0, 1));
                end
                PLAN_HUGE: begin
                    push_buf(k == 0, $urandom | 32'hC000_0000, step,
                             clamp_step(step + $urandom_range(0, 3)));
                    step = clamp_step(step + $urandom_range(0, 2));
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: bytes = $urandom_range(1, 64);
                        1: bytes = $urandom_range(1, 8) * 256;
                        2: bytes = $urandom_range(1, 100000);
                        default: bytes = $urandom;
                    endcase
                    if ($urandom_range(0, 19) == 0)
                        last = clamp_step(step - $urandom_range(1, 10));
                    else
                        last = clamp_step(step + $urandom_range(0, 12));
                    push_buf(k == 0, bytes, step, last);
                    step = clamp_step(step + $urandom_range(0, 3));
                end
            endcase
        end
        return n;
    endfunction

    function automatic void queue_plans(int n_bufs);
        int made;
        int r;
        made = 0;
        while (made < n_bufs) begin
            r = $urandom_range(0, 99);
            if (r < 65)      made += gen_plan(PLAN_NORMAL);
            else if (r < 75) made += gen_plan(PLAN_FILL);
            else if (r < 85) made += gen_plan(PLAN_HUGE);
            else             made += gen_plan(PLAN_NOISE);
        end
    endfunction

    task automatic wait_drained();
        while (pending_bufs.size() != 0 || offering || due_placements.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_batch(logic [BATCH_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        batch_reg  = 64'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Input driver: offers queued buffers with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (beat_taken) begin
                beat_taken = 1'b0;
                offering   = 1'b0;
                send_gap   = in_idle_en ? pick_gap() : 0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bufs.size() != 0) begin
                    offered  <= pending_bufs.pop_front();
                    offering = 1'b1;
                end
            end
            i_in_valid <= offering;
        end
    end

    // Result receiver: random stalls, plus long hold-offs on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (out_idle_en && stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = out_idle_en ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_placement want;
        bit         moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                due_placements.insert(due_placements.size(), place_buffer(offered));
                beat_taken = 1'b1;
                bufs_sent++;
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (due_placements.size() == 0) begin
                    $error("result beat with no buffer outstanding");
                    fails++;
                end else begin
                    want = due_placements.pop_front();
                    if (want.reused) reuses_seen++;
                    if (want.error) errors_seen++;
                    if (o_offset !== want.offset) begin
                        $error("offset: expected %0h, got %0h", want.offset, o_offset);
                        fails++;
                    end
                    if (o_reused !== want.reused) begin
                        $error("reused: expected %0b, got %0b", want.reused, o_reused);
                        fails++;
                    end
                    if (o_arena_size !== want.arena_size) begin
                        $error("arena_size: expected %0h, got %0h",
                               want.arena_size, o_arena_size);
                        fails++;
                    end
                    if (o_error !== want.error) begin
                        $error("error: expected %0b, got %0b", want.error, o_error);
                        fails++;
                    end
                end
            end
            stuck_cycles = moved ? 0 : stuck_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stuck_cycles >= STUCK_LIMIT);
        $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed buffers at the reset batch of one.
        push_buf(1, 0, 0, 0);                    // zero-byte buffer
        push_buf(0, 1000, 0, 2);
        push_buf(0, 100, 1, 0);                  // last use before first use
        push_buf(0, 50, 3, 4);                   // best fit picks the smaller block
        push_buf(0, 500, 4, 5);
        push_buf(0, 500, 4, 5);
        push_buf(0, 400, 6, 7);                  // best fit again picks the smaller block
        push_buf(0, 32'hFFFF_FFFF, 8, 255);
        push_buf(0, 1, 255, 0);
        push_buf(0, 1000, 254, 254);             // exact-size reuse of the 1000-byte block
        push_buf(1, 32'hFFFF_FFFF, 255, 255);    // new plan with every field at its top
        push_buf(0, 32'hFFFF_FFFF, 255, 255);    // same step, so no reuse
        push_buf(1, 32'h5555_5555, 8'h55, 8'hAA);
        push_buf(0, 32'hAAAA_AAAA, 8'hAA, 8'h55);
        push_buf(1, 7, 0, 255);
        push_buf(0, 7, 0, 0);
        push_buf(0, 0, 1, 1);
        push_buf(0, 255, 2, 3);
        push_buf(0, 257, 4, 4);
        push_buf(0, 256, 5, 5);
        wait_drained();

        set_batch(11'd1024);
        void'(gen_plan(PLAN_FILL));              // runs the block table full
        queue_plans(230);
        wait_drained();

        set_batch(11'd0);                        // zero batch: every buffer is empty
        queue_plans(100);
        wait_drained();

        set_batch(11'd2047);
        void'(gen_plan(PLAN_HUGE));              // meant to push the arena past 48 bits
        queue_plans(210);
        wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        set_batch(BATCH_W'($urandom_range(2, 1023)));
        queue_plans(300);
        holds_asked++;
        wait_drained();

        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        set_batch(11'd1);
        void'(gen_plan(PLAN_FILL));
        queue_plans(250);
        wait_drained();

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        set_batch(BATCH_W'($urandom_range(1, 16)));
        queue_plans(150);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (due_placements.size() != 0) begin
            $error("%0d placements never arrived", due_placements.size());
            fails++;
        end
        $display("Placed %0d buffers under %0d batch settings: %0d reused, %0d rejected.",
                 bufs_sent, settings_used, reuses_seen, errors_seen);
        if (fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
